/* rtl/slu_pkg.sv */
// slu_pkg: shared types and constants for the console serial line unit
// no dependencies; every other rtl file imports this package

package slu_pkg;

   localparam int AddrWidth = 18;
   localparam int DataWidth = 16;
   localparam int GapWidth  = 16;
   localparam int TickWidth = 32;
   localparam int CsrWidth  = 18;

   localparam logic [AddrWidth-1:0] BaseAddrReset = AddrWidth'(262000);
   localparam logic [GapWidth-1:0]  MinGapReset   = GapWidth'(315);

   // status bit positions
   localparam int DoneBit   = 7;
   localparam int EnableBit = 6;
   // transmitter buffer pending flag
   localparam int PendBit   = 8;

   // special receive bytes
   localparam logic [7:0] CtlByte1 = 8'o201;
   localparam logic [7:0] CtlByte2 = 8'o202;
   localparam logic [7:0] CtlByte3 = 8'o203;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_RECV  = 2'd2,
      MODE_POLL  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      IRQ_NONE  = 2'd0,
      IRQ_RAISE = 2'd1,
      IRQ_CLEAR = 2'd2
   } irq_action_type;

   typedef enum logic [2:0] {
      CTL_NONE  = 3'd0,
      CTL_ONE   = 3'd1,
      CTL_TWO   = 3'd2,
      CTL_THREE = 3'd3,
      CTL_OTHER = 3'd4
   } control_code_type;

   // register offsets from the base address
   localparam logic [AddrWidth-1:0] OfsRxStatus = AddrWidth'(0);
   localparam logic [AddrWidth-1:0] OfsRxBuffer = AddrWidth'(2);
   localparam logic [AddrWidth-1:0] OfsTxStatus = AddrWidth'(4);
   localparam logic [AddrWidth-1:0] OfsTxBuffer = AddrWidth'(6);

   // configuration register indexes
   typedef enum logic {
      CSR_BASE_ADDRESS = 1'b0,
      CSR_MIN_TX_GAP   = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type               mode;
      logic [AddrWidth-1:0]   address;
      logic [DataWidth-1:0]   write_data;
      logic [7:0]             rx_byte;
      logic [TickWidth-1:0]   now_ticks;
      logic                   line_ready;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0]   read_data;
      logic                   bus_error;
      logic                   rx_accepted;
      control_code_type       control_code;
      irq_action_type         rx_irq_action;
      irq_action_type         tx_irq_action;
      logic                   tx_valid;
      logic [7:0]             tx_byte;
   } rsp_type;

endpackage

/* rtl/slu_if.sv */
// slu_if: valid/ready channel interfaces for request and response words
// depends on slu_pkg for the payload structs

interface slu_req_if;
   import slu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slu_rsp_if;
   import slu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/serial_line_unit_registers.sv */
// serial_line_unit_registers: top level of the console serial line unit
// depends on slu_pkg, slu_if (channel interfaces) and slu_core
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+--------------------------------------
//   req_ch   | in  | valid/ready      | mode, address, write data, rx byte,
//            |     |                  | tick stamp, line ready
//   rsp_ch   | out | valid/ready      | read data, error, rx/tx results, irqs
//   csr_*    | in  | write enable     | base address, min transmit gap
//
// one word per cycle sustained while rsp_ch is not stalled; a word waits in
// the input register, is decoded and applied to device state by slu_core
// when it moves on, and its response lands in the output register on that
// same edge, from which it is offered.
// reset is synchronous: both valid flags clear; device state and config take their reset values.
// a stalled response holds the output register; the input register keeps
// accepting as long as its word can move into a free or draining output.

module serial_line_unit_registers (
   input  logic                          clock,
   input  logic                          reset,
   slu_req_if.sink                       req_ch,
   slu_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  slu_pkg::csr_index_type        csr_index,
   input  logic [slu_pkg::CsrWidth-1:0]  csr_wdata
);
   import slu_pkg::*;

   // config registers
   logic [AddrWidth-1:0] base_addr_ff;
   logic [GapWidth-1:0]  min_gap_ff;

   // input stage
   logic    in_valid_ff;
   req_type in_word_ff;

   // output stage
   logic    out_valid_ff;
   rsp_type out_word_ff;
   rsp_type core_result;

   logic out_free;
   logic advance;

   // output register frees up when empty or being taken this cycle
   assign out_free = !out_valid_ff || rsp_ch.ready;
   // the buffered word moves on, updating device state
   assign advance  = in_valid_ff && out_free;

   assign req_ch.ready = !in_valid_ff || out_free;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff <= BaseAddrReset;
         min_gap_ff   <= MinGapReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_addr_ff <= csr_wdata[AddrWidth-1:0];
            CSR_MIN_TX_GAP:   min_gap_ff   <= csr_wdata[GapWidth-1:0];
            default:          base_addr_ff <= base_addr_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_word_ff <= req_ch.data;
      end
   end

   slu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (in_word_ff),
      .base_address (base_addr_ff),
      .min_tx_gap   (min_gap_ff),
      .result       (core_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= core_result;
      end
   end

endmodule

/* rtl/slu_core.sv */
// slu_core: device state registers and the per-word decode and update logic
// depends on slu_pkg

module slu_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  slu_pkg::req_type          item,
   input  logic [slu_pkg::AddrWidth-1:0] base_address,
   input  logic [slu_pkg::GapWidth-1:0]  min_tx_gap,
   output slu_pkg::rsp_type          result
);
   import slu_pkg::*;

   logic [DataWidth-1:0] rx_status_ff, rx_status_in;
   logic [7:0]           rx_data_ff, rx_data_in;
   logic [DataWidth-1:0] tx_status_ff, tx_status_in;
   logic [8:0]           tx_data_ff, tx_data_in;
   logic [TickWidth-1:0] last_send_ff, last_send_in;
   logic                 time_known_ff, time_known_in;

   logic [AddrWidth-1:0] offset;
   logic [TickWidth-1:0] elapsed;
   logic                 gap_ok;
   logic [DataWidth-1:0] status_wr;

   assign offset  = item.address - base_address;
   assign elapsed = item.now_ticks - last_send_ff;
   assign gap_ok  = !time_known_ff || (elapsed >= TickWidth'(min_tx_gap));

   always_comb begin
      rx_status_in  = rx_status_ff;
      rx_data_in    = rx_data_ff;
      tx_status_in  = tx_status_ff;
      tx_data_in    = tx_data_ff;
      last_send_in  = last_send_ff;
      time_known_in = time_known_ff;
      result        = '0;
      status_wr     = item.write_data;

      unique case (item.mode)
         MODE_READ, MODE_WRITE: begin
            if (offset == OfsRxStatus) begin
               if (item.mode == MODE_WRITE) begin
                  rx_status_in = status_wr;
                  rx_status_in[DoneBit] = rx_status_ff[DoneBit];
               end else begin
                  result.read_data = rx_status_ff;
               end
            end else if (offset == OfsRxBuffer) begin
               rx_status_in[DoneBit] = 1'b0;
               if (item.mode == MODE_READ) begin
                  result.read_data = {8'd0, rx_data_ff};
               end
            end else if (offset == OfsTxStatus) begin
               if (item.mode == MODE_WRITE) begin
                  tx_status_in = status_wr;
                  tx_status_in[DoneBit] = tx_status_ff[DoneBit];
                  result.tx_irq_action =
                     (tx_status_ff[DoneBit] && status_wr[EnableBit]) ? IRQ_RAISE : IRQ_CLEAR;
               end else begin
                  result.read_data = tx_status_ff;
               end
            end else if (offset == OfsTxBuffer) begin
               if (item.mode == MODE_WRITE) begin
                  tx_data_in = {1'b1, 1'b0, item.write_data[6:0]};
                  tx_status_in[DoneBit] = 1'b0;
               end else begin
                  result.read_data = {8'd0, tx_data_ff[7:0]};
               end
            end else begin
               result.bus_error = 1'b1;
            end
         end
         MODE_RECV: begin
            if (!rx_status_ff[DoneBit]) begin
               result.rx_accepted = 1'b1;
               rx_data_in = item.rx_byte;
               if (item.rx_byte[7]) begin
                  if (item.rx_byte == CtlByte1) begin
                     result.control_code = CTL_ONE;
                  end else if (item.rx_byte == CtlByte2) begin
                     result.control_code = CTL_TWO;
                  end else if (item.rx_byte == CtlByte3) begin
                     result.control_code = CTL_THREE;
                  end else begin
                     result.control_code = CTL_OTHER;
                  end
               end else begin
                  rx_status_in[DoneBit] = 1'b1;
                  result.rx_irq_action = rx_status_ff[EnableBit] ? IRQ_RAISE : IRQ_CLEAR;
               end
            end
         end
         MODE_POLL: begin
            if (!tx_status_ff[DoneBit]) begin
               if (!gap_ok) begin
                  // too soon after the last send
                  if (!tx_status_ff[EnableBit]) begin
                     result.tx_irq_action = IRQ_CLEAR;
                  end
               end else begin
                  last_send_in  = item.now_ticks;
                  time_known_in = 1'b1;
                  if (tx_data_ff == '0 || item.line_ready) begin
                     if (tx_data_ff != '0) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = tx_data_ff[7:0];
                        tx_data_in      = '0;
                     end
                     tx_status_in[DoneBit] = 1'b1;
                     result.tx_irq_action =
                        tx_status_ff[EnableBit] ? IRQ_RAISE : IRQ_CLEAR;
                  end
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_status_ff  <= '0;
         rx_data_ff    <= '0;
         tx_status_ff  <= DataWidth'(1) << DoneBit;
         tx_data_ff    <= '0;
         last_send_ff  <= '0;
         time_known_ff <= 1'b0;
      end else if (step) begin
         rx_status_ff  <= rx_status_in;
         rx_data_ff    <= rx_data_in;
         tx_status_ff  <= tx_status_in;
         tx_data_ff    <= tx_data_in;
         last_send_ff  <= last_send_in;
         time_known_ff <= time_known_in;
      end
   end

endmodule

/* rtl/slu_checker.sv */
// slu_checker: port-level assertions for the serial line unit, plus bind
// depends on slu_pkg; attaches to serial_line_unit_registers

module slu_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  slu_pkg::rsp_type rsp_data
);
   import slu_pkg::*;

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // a sent byte always completes the transmitter and updates its interrupt
   a_send_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |->
         (rsp_data.tx_irq_action == IRQ_RAISE || rsp_data.tx_irq_action == IRQ_CLEAR))
      else $error("byte sent without transmit interrupt update");

   // a bad address has no side effects visible in the response
   a_bus_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_error |->
         rsp_data.read_data == '0 && !rsp_data.tx_valid &&
         rsp_data.tx_irq_action == IRQ_NONE && rsp_data.rx_irq_action == IRQ_NONE)
      else $error("bus error word carries other results");

   // control bytes are accepted but never raise the receiver interrupt
   a_control: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.control_code != CTL_NONE |->
         rsp_data.rx_accepted && rsp_data.rx_irq_action == IRQ_NONE)
      else $error("control byte with receiver interrupt request");

endmodule

bind serial_line_unit_registers slu_checker u_slu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for serial_line_unit_registers, random and directed words
// depends on slu_pkg, slu_if and the rtl top level; predicts every response in a class

module tb_top;
   import slu_pkg::*;

   // cycles of response back-pressure for the fill-up test
   localparam int HoldOffCycles = 300;
   // cycles with no word moving on either channel before giving up
   localparam int WatchdogLimit = 4000;
   // covers the input and output registers, plus margin
   localparam int DrainCycles   = 6;
   localparam int NumPhases     = 8;
   localparam int WordsPerPhase = 250;

   localparam logic [DataWidth-1:0] DoneMask   = DataWidth'(1) << DoneBit;
   localparam logic [DataWidth-1:0] EnableMask = DataWidth'(1) << EnableBit;

   // ------------------------------------------------------------------
   // device model and response scoreboard
   // ------------------------------------------------------------------
   class slu_scoreboard;
      logic [AddrWidth-1:0] base_addr;
      logic [GapWidth-1:0]  min_gap;
      logic [DataWidth-1:0] rx_stat;
      logic [7:0]           rx_buf;
      logic [DataWidth-1:0] tx_stat;
      logic [8:0]           tx_buf;
      logic [TickWidth-1:0] last_send;
      bit                   send_known;
      rsp_type              expected_rsp[$];
      int unsigned          errors;

      function new();
         base_addr  = BaseAddrReset;
         min_gap    = MinGapReset;
         rx_stat    = '0;
         rx_buf     = '0;
         tx_stat    = DoneMask;
         tx_buf     = '0;
         last_send  = '0;
         send_known = 1'b0;
         errors     = 0;
      endfunction

      function void write_config(csr_index_type idx, logic [CsrWidth-1:0] value);
         if (idx == CSR_BASE_ADDRESS) begin
            base_addr = value[AddrWidth-1:0];
         end else begin
            min_gap = value[GapWidth-1:0];
         end
      endfunction

      // apply one accepted request word to the model and queue its response
      function void note_request(req_type r);
         rsp_type              rsp;
         logic [AddrWidth-1:0] ofs;
         logic [TickWidth-1:0] delta;
         bit                   go;
         rsp = '0;
         ofs = r.address - base_addr;
         case (r.mode)
            MODE_READ, MODE_WRITE: begin
               case (ofs)
                  OfsRxStatus: begin
                     if (r.mode == MODE_WRITE) begin
                        rx_stat = (rx_stat & DoneMask) | (r.write_data & ~DoneMask);
                     end else begin
                        rsp.read_data = rx_stat;
                     end
                  end
                  OfsRxBuffer: begin
                     // any access to the buffer consumes the received byte
                     rx_stat[DoneBit] = 1'b0;
                     if (r.mode == MODE_READ) rsp.read_data = DataWidth'(rx_buf);
                  end
                  OfsTxStatus: begin
                     if (r.mode == MODE_WRITE) begin
                        tx_stat = (tx_stat & DoneMask) | (r.write_data & ~DoneMask);
                        rsp.tx_irq_action = (tx_stat[DoneBit] && tx_stat[EnableBit]) ?
                                            IRQ_RAISE : IRQ_CLEAR;
                     end else begin
                        rsp.read_data = tx_stat;
                     end
                  end
                  OfsTxBuffer: begin
                     if (r.mode == MODE_WRITE) begin
                        tx_buf = {1'b1, 1'b0, r.write_data[6:0]};
                        tx_stat[DoneBit] = 1'b0;
                     end else begin
                        rsp.read_data = DataWidth'(tx_buf[7:0]);
                     end
                  end
                  default: rsp.bus_error = 1'b1;
               endcase
            end
            MODE_RECV: begin
               if (!rx_stat[DoneBit]) begin
                  rsp.rx_accepted = 1'b1;
                  rx_buf = r.rx_byte;
                  if (r.rx_byte[7]) begin
                     case (r.rx_byte)
                        CtlByte1: rsp.control_code = CTL_ONE;
                        CtlByte2: rsp.control_code = CTL_TWO;
                        CtlByte3: rsp.control_code = CTL_THREE;
                        default:  rsp.control_code = CTL_OTHER;
                     endcase
                  end else begin
                     rx_stat[DoneBit] = 1'b1;
                     rsp.rx_irq_action = rx_stat[EnableBit] ? IRQ_RAISE : IRQ_CLEAR;
                  end
               end
            end
            default: begin
               if (!tx_stat[DoneBit]) begin
                  go = 1'b1;
                  delta = r.now_ticks - last_send;
                  if (!send_known) begin
                     last_send  = r.now_ticks;
                     send_known = 1'b1;
                  end else if (delta < TickWidth'(min_gap)) begin
                     if (!tx_stat[EnableBit]) rsp.tx_irq_action = IRQ_CLEAR;
                     go = 1'b0;
                  end else begin
                     last_send = r.now_ticks;
                  end
                  if (go && tx_buf != '0) begin
                     if (!r.line_ready) begin
                        go = 1'b0;
                     end else begin
                        rsp.tx_valid = 1'b1;
                        rsp.tx_byte  = tx_buf[7:0];
                        tx_buf       = '0;
                     end
                  end
                  if (go) begin
                     tx_stat[DoneBit] = 1'b1;
                     rsp.tx_irq_action = tx_stat[EnableBit] ? IRQ_RAISE : IRQ_CLEAR;
                  end
               end
            end
         endcase
         expected_rsp.push_back(rsp);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("response word with nothing expected: %p", got);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("bus_error", want.bus_error, got.bus_error);
            compare_field("rx_accepted", want.rx_accepted, got.rx_accepted);
            compare_field("control_code", want.control_code, got.control_code);
            compare_field("rx_irq_action", want.rx_irq_action, got.rx_irq_action);
            compare_field("tx_irq_action", want.tx_irq_action, got.tx_irq_action);
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
         end
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset, channels and the block itself
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CsrWidth-1:0]   csr_wdata;

   slu_req_if req_ch ();
   slu_rsp_if rsp_ch ();

   slu_scoreboard sb = new();

   // tick stamp for random transmit polls, advanced on each one
   logic [TickWidth-1:0] tick_now;
   // no idling on either side while set
   bit steady;
   // one-shot request for a long response stall
   bit hold_off_go;
   int unsigned idle_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   serial_line_unit_registers i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // monitor: both channels sampled at the edge, plus the watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
         // anything moving resets the stall counter
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // response side: random back-pressure, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            // stall long enough for the pipeline to fill and push back
            rsp_ch.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // request side helpers
   // ------------------------------------------------------------------

   // offer one word, with random idle cycles in front of it, and wait until taken
   task automatic send_request(input req_type r);
      while (!steady && $urandom_range(0, 99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering and let every expected response come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // both registers back to back, only while the block is idle
   task automatic apply_settings(input logic [CsrWidth-1:0] base,
                                 input logic [CsrWidth-1:0] gap);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base;
      @(posedge clock);
      sb.write_config(CSR_BASE_ADDRESS, base);
      csr_index <= CSR_MIN_TX_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      sb.write_config(CSR_MIN_TX_GAP, gap);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(mode_type m, logic [AddrWidth-1:0] addr,
                                        logic [DataWidth-1:0] wdata, logic [7:0] rxb,
                                        logic [TickWidth-1:0] ticks, logic ready);
      req_type r;
      r.mode       = m;
      r.address    = addr;
      r.write_data = wdata;
      r.rx_byte    = rxb;
      r.now_ticks  = ticks;
      r.line_ready = ready;
      return r;
   endfunction

   // poll stamps hover around the gap so both too-soon and on-time polls happen
   function automatic logic [TickWidth-1:0] next_poll_ticks();
      logic [TickWidth-1:0] gap;
      gap = TickWidth'(sb.min_gap);
      case ($urandom_range(0, 9))
         0:       tick_now = $urandom;
         1, 2:    tick_now = tick_now + $urandom_range(0, gap);
         3:       tick_now = tick_now + ((gap == 0) ? gap : gap - 1);
         4, 5, 6: tick_now = tick_now + gap + $urandom_range(0, 3);
         default: tick_now = tick_now + $urandom;
      endcase
      return tick_now;
   endfunction

   // mostly legal register accesses, some odd or wild addresses
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.write_data = DataWidth'($urandom);
      r.rx_byte    = 8'($urandom);
      r.now_ticks  = $urandom;
      r.line_ready = 1'($urandom_range(0, 1));
      r.address    = AddrWidth'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: r.mode = MODE_READ;
         3, 4, 5: r.mode = MODE_WRITE;
         6, 7:    r.mode = MODE_RECV;
         default: r.mode = MODE_POLL;
      endcase
      pick = int'($urandom_range(0, 99));
      if (pick < 85) begin
         r.address = sb.base_addr + AddrWidth'(2 * $urandom_range(0, 3));
      end else if (pick < 92) begin
         r.address = sb.base_addr + AddrWidth'(2 * $urandom_range(0, 3) + 1);
      end
      // control bytes are rare in a uniform draw
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 2))
            0:       r.rx_byte = CtlByte1;
            1:       r.rx_byte = CtlByte2;
            default: r.rx_byte = CtlByte3;
         endcase
      end
      if (r.mode == MODE_POLL) r.now_ticks = next_poll_ticks();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [AddrWidth-1:0] b;
      logic [CsrWidth-1:0]  base_set [NumPhases];
      logic [CsrWidth-1:0]  gap_set [NumPhases];
      bit                   leftover;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_BASE_ADDRESS;
      csr_wdata    = '0;
      steady       = 1'b0;
      hold_off_go  = 1'b0;
      tick_now     = 32'hFFFF_F000;

      // settings per phase: reset values, both extremes, wrap of the window
      base_set = '{CsrWidth'(BaseAddrReset), 18'd0, 18'h3FFFF, 18'h3FFFC,
                   CsrWidth'($urandom), 18'h3FFFA, 18'o777560, CsrWidth'($urandom)};
      gap_set  = '{CsrWidth'(MinGapReset), 18'd0, 18'hFFFF, 18'd1,
                   CsrWidth'($urandom_range(0, 65535)), 18'd2, 18'd315,
                   CsrWidth'($urandom_range(0, 1000))};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      b = BaseAddrReset;
      send_request(make_req(MODE_READ,  b,                  '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_READ,  b + AddrWidth'(4),  '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_READ,  b + AddrWidth'(6),  '0,       '0, '0, 1'b0));
      // unmapped and odd addresses give a bus error
      send_request(make_req(MODE_READ,  b + AddrWidth'(1),  '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_WRITE, b + AddrWidth'(8),  16'hFFFF, '0, '0, 1'b0));
      send_request(make_req(MODE_READ,  '0,                 '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_WRITE, 18'h3FFFF,          16'hFFFF, '0, '0, 1'b0));
      // receiver: enable, take a byte, refuse the next, consume it
      send_request(make_req(MODE_WRITE, b,                  16'hFFFF, '0, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       8'h41, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       8'h42, '0, 1'b0));
      send_request(make_req(MODE_READ,  b + AddrWidth'(2),  '0,       '0, '0, 1'b0));
      // high-bit bytes: three control codes and two others
      send_request(make_req(MODE_RECV,  '0,                 '0,       CtlByte1, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       CtlByte2, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       CtlByte3, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       8'hFF, '0, 1'b0));
      send_request(make_req(MODE_RECV,  '0,                 '0,       8'h80, '0, 1'b0));
      send_request(make_req(MODE_READ,  b,                  '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_WRITE, b + AddrWidth'(2),  '0,       '0, '0, 1'b0));
      // transmitter: enable with done set, poll while done, then load a byte
      send_request(make_req(MODE_WRITE, b + AddrWidth'(4),  16'hFFFF, '0, '0, 1'b0));
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, '0, 1'b1));
      send_request(make_req(MODE_WRITE, b + AddrWidth'(6),  16'hFFFF, '0, '0, 1'b0));
      send_request(make_req(MODE_READ,  b + AddrWidth'(6),  '0,       '0, '0, 1'b0));
      // first poll with line busy, a too-soon poll, then the send
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'd1000, 1'b0));
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'd1100, 1'b1));
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'd1315, 1'b1));
      // enable off: a too-soon poll clears the interrupt
      send_request(make_req(MODE_WRITE, b + AddrWidth'(4),  '0,       '0, '0, 1'b0));
      send_request(make_req(MODE_WRITE, b + AddrWidth'(6),  16'h0055, '0, '0, 1'b0));
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'd1320, 1'b1));
      // tick stamp wraps past the top of the counter
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'hFFFF_FFFF, 1'b0));
      send_request(make_req(MODE_POLL,  '0,                 '0,       '0, 32'd314, 1'b1));

      for (int p = 0; p < NumPhases; p++) begin
         if (p > 0) begin
            drain();
            apply_settings(base_set[p], gap_set[p]);
         end
         // one phase runs without any idling on either side
         steady = (p == 3);
         for (int k = 0; k < WordsPerPhase; k++) begin
            if (p == 2 && k == 100) hold_off_go = 1'b1;
            send_request(random_request());
         end
      end

      drain();
      leftover = (sb.outstanding() != 0);
      if (leftover) $error("%0d expected responses never arrived", sb.outstanding());
      if (sb.errors == 0 && !leftover) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
